[src/tli_pkg.sv]
// -----------------------------------------------------------------------------
// tli_pkg
// Shared constants, codes and types for the tape language interpreter core.
// -----------------------------------------------------------------------------
package tli_pkg;

   localparam int TAPE_CELLS    = 32768;
   localparam int PROGRAM_CHARS = 4096;

   localparam int DP_W = $clog2(TAPE_CELLS);
   localparam int PA_W = $clog2(PROGRAM_CHARS);
   localparam int PC_W = PA_W + 1;

   localparam logic [DP_W-1:0] DP_MAX   = DP_W'(TAPE_CELLS - 1);
   localparam logic [PC_W-1:0] PROG_MAX = PC_W'(PROGRAM_CHARS);

   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      OP_CLEAR_PROG = 2'd0,
      OP_APPEND     = 2'd1,
      OP_STEP       = 2'd2,
      OP_RESET      = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_CLEAR  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   typedef struct packed {
      logic            clear_start;
      logic            wr_en;
      logic [DP_W-1:0] wr_addr;
      logic [7:0]      wr_data;
   } tape_cmd_type;

   typedef struct packed {
      logic            wr_en;
      logic [PA_W-1:0] wr_addr;
      logic [7:0]      wr_data;
   } prog_wr_type;

endpackage

[src/tli_tape.sv]
// -----------------------------------------------------------------------------
// tli_tape
// Tape cell memory with registered read and a one-cell-per-cycle clear sweep.
// -----------------------------------------------------------------------------
module tli_tape (
   input  logic                      clock,
   input  logic                      reset,
   input  tli_pkg::tape_cmd_type     cmd,
   input  logic [tli_pkg::DP_W-1:0]  rd_addr,
   output logic [7:0]                rd_data,
   output logic                      busy
);

   logic [7:0]               cells_ff [tli_pkg::TAPE_CELLS];
   logic [7:0]               rd_data_ff;
   logic                     clearing_ff;
   logic                     clearing_in;
   logic [tli_pkg::DP_W-1:0] clr_cnt_ff;
   logic [tli_pkg::DP_W-1:0] clr_cnt_in;
   logic                     wr_en;
   logic [tli_pkg::DP_W-1:0] wr_addr;
   logic [7:0]               wr_data;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (cmd.clear_start) begin
         clearing_in = 1'b1;
         clr_cnt_in  = '0;
      end else if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == tli_pkg::DP_MAX) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = 8'd0;
      end else begin
         wr_en   = cmd.wr_en;
         wr_addr = cmd.wr_addr;
         wr_data = cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

[src/tli_prog.sv]
// -----------------------------------------------------------------------------
// tli_prog
// Program character store, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module tli_prog (
   input  logic                      clock,
   input  tli_pkg::prog_wr_type      wr,
   input  logic [tli_pkg::PA_W-1:0]  rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] chars_ff [tli_pkg::PROGRAM_CHARS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         chars_ff[wr.wr_addr] <= wr.wr_data;
      end
      rd_data_ff <= chars_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tape_language_interpreter_core.sv]
// -----------------------------------------------------------------------------
// tape_language_interpreter_core
// Stepped eight-command tape machine with program store and bracket scanner.
// -----------------------------------------------------------------------------
// Each request item clears the program, appends one character, resets the
// machine or executes one instruction, and yields exactly one response item.
// Program edits go from idle straight to the response state, and simple
// instructions pass through the decode state first; the response state waits
// while the response side is stalled. A bracket that has to look for its
// partner walks the program store one character per cycle through the single
// read port. Machine reset and an unmatched '[' clear the tape with a sweep of
// one cell per cycle over all 32768 cells; the same sweep runs after reset,
// and no request is taken until it is done.
module tape_language_interpreter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // program_char[7:0], input_byte[15:8]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // output_byte[7:0], finished[8], error_unclosed[9]
   output logic        rsp_tuser   // output_valid[0]
);

   localparam int DP_W = tli_pkg::DP_W;
   localparam int PA_W = tli_pkg::PA_W;
   localparam int PC_W = tli_pkg::PC_W;

   tli_pkg::state_type    state_ff, state_in;
   tli_pkg::tape_cmd_type tape_cmd;
   tli_pkg::prog_wr_type  prog_wr;
   tli_pkg::op_type       req_op;

   logic [DP_W-1:0] dp_ff, dp_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [PC_W-1:0] len_ff, len_in;
   logic            stopped_ff, stopped_in;
   logic [PC_W-1:0] scan_idx_ff, scan_idx_in;
   logic [PC_W-1:0] depth_ff, depth_in;
   logic            scan_back_ff, scan_back_in;
   logic [7:0]      cell_ff, cell_in;
   logic [7:0]      ibyte_ff, ibyte_in;
   logic            res_ovalid_ff, res_ovalid_in;
   logic [7:0]      res_byte_ff, res_byte_in;
   logic            res_err_ff, res_err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;

   logic [PA_W-1:0] prog_rd_addr;
   logic [7:0]      prog_rd_data;
   logic [7:0]      tape_rd_data;
   logic            tape_busy;
   logic            req_fire;
   logic [PC_W-1:0] pc_next;
   logic [PC_W-1:0] scan_up;
   logic [PC_W-1:0] scan_down;
   logic            finished;

   tli_tape u_tape (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tape_cmd),
      .rd_addr (dp_ff),
      .rd_data (tape_rd_data),
      .busy    (tape_busy)
   );

   tli_prog u_prog (
      .clock   (clock),
      .wr      (prog_wr),
      .rd_addr (prog_rd_addr),
      .rd_data (prog_rd_data)
   );

   assign req_tready = (state_ff == tli_pkg::S_IDLE) && !tape_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = tli_pkg::op_type'(req_tuser);
   assign pc_next    = pc_ff + 1'b1;
   assign scan_up    = scan_idx_ff + 1'b1;
   assign scan_down  = scan_idx_ff - 1'b1;
   assign finished   = stopped_ff || (pc_ff >= len_ff);

   always_comb begin
      state_in      = state_ff;
      dp_in         = dp_ff;
      pc_in         = pc_ff;
      len_in        = len_ff;
      stopped_in    = stopped_ff;
      scan_idx_in   = scan_idx_ff;
      depth_in      = depth_ff;
      scan_back_in  = scan_back_ff;
      cell_in       = cell_ff;
      ibyte_in      = ibyte_ff;
      res_ovalid_in = res_ovalid_ff;
      res_byte_in   = res_byte_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      tape_cmd      = '0;
      prog_wr       = '0;
      prog_rd_addr  = pc_ff[PA_W-1:0];

      unique case (state_ff)
         tli_pkg::S_IDLE: begin
            if (req_fire) begin
               res_ovalid_in = 1'b0;
               res_byte_in   = 8'd0;
               res_err_in    = 1'b0;
               ibyte_in      = req_tdata[15:8];
               state_in      = tli_pkg::S_DONE;
               unique case (req_op)
                  tli_pkg::OP_CLEAR_PROG: begin
                     len_in     = '0;
                     pc_in      = '0;
                     stopped_in = 1'b0;
                  end
                  tli_pkg::OP_APPEND: begin
                     if (len_ff != tli_pkg::PROG_MAX) begin
                        prog_wr.wr_en   = 1'b1;
                        prog_wr.wr_addr = len_ff[PA_W-1:0];
                        prog_wr.wr_data = req_tdata[7:0];
                        len_in          = len_ff + 1'b1;
                     end
                  end
                  tli_pkg::OP_STEP: begin
                     if (!finished) begin
                        state_in = tli_pkg::S_DECODE;
                     end
                  end
                  tli_pkg::OP_RESET: begin
                     tape_cmd.clear_start = 1'b1;
                     dp_in      = '0;
                     pc_in      = '0;
                     stopped_in = 1'b0;
                     state_in   = tli_pkg::S_CLEAR;
                  end
                  default: begin
                     state_in = tli_pkg::S_DONE;
                  end
               endcase
            end
         end

         tli_pkg::S_DECODE: begin
            cell_in  = tape_rd_data;
            pc_in    = pc_next;
            state_in = tli_pkg::S_DONE;
            unique case (prog_rd_data)
               tli_pkg::CH_RIGHT: begin
                  if (dp_ff != tli_pkg::DP_MAX) begin
                     dp_in = dp_ff + 1'b1;
                  end
               end
               tli_pkg::CH_LEFT: begin
                  if (dp_ff != '0) begin
                     dp_in = dp_ff - 1'b1;
                  end
               end
               tli_pkg::CH_INC: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_addr = dp_ff;
                  tape_cmd.wr_data = tape_rd_data + 8'd1;
               end
               tli_pkg::CH_DEC: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_addr = dp_ff;
                  tape_cmd.wr_data = tape_rd_data - 8'd1;
               end
               tli_pkg::CH_OUT: begin
                  res_ovalid_in = 1'b1;
                  res_byte_in   = tape_rd_data;
               end
               tli_pkg::CH_IN: begin
                  tape_cmd.wr_en   = 1'b1;
                  tape_cmd.wr_addr = dp_ff;
                  tape_cmd.wr_data = ibyte_ff;
               end
               tli_pkg::CH_OPEN: begin
                  pc_in        = pc_ff;
                  scan_back_in = 1'b0;
                  depth_in     = PC_W'(1);
                  scan_idx_in  = pc_next;
                  prog_rd_addr = pc_next[PA_W-1:0];
                  state_in     = tli_pkg::S_SCAN;
               end
               tli_pkg::CH_CLOSE: begin
                  if (tape_rd_data != 8'd0 && pc_ff != '0) begin
                     pc_in        = pc_ff;
                     scan_back_in = 1'b1;
                     depth_in     = PC_W'(1);
                     scan_idx_in  = pc_ff - 1'b1;
                     prog_rd_addr = pc_in[PA_W-1:0] - 1'b1;
                     state_in     = tli_pkg::S_SCAN;
                  end
               end
               default: begin
                  pc_in = pc_next;
               end
            endcase
         end

         tli_pkg::S_SCAN: begin
            if (!scan_back_ff) begin
               if (scan_idx_ff >= len_ff) begin
                  // no partner for the open bracket
                  tape_cmd.clear_start = 1'b1;
                  dp_in      = '0;
                  pc_in      = '0;
                  stopped_in = 1'b1;
                  res_err_in = 1'b1;
                  state_in   = tli_pkg::S_CLEAR;
               end else if (prog_rd_data == tli_pkg::CH_CLOSE && depth_ff == PC_W'(1)) begin
                  pc_in    = (cell_ff == 8'd0) ? scan_up : pc_next;
                  state_in = tli_pkg::S_DONE;
               end else begin
                  if (prog_rd_data == tli_pkg::CH_OPEN) begin
                     depth_in = depth_ff + 1'b1;
                  end else if (prog_rd_data == tli_pkg::CH_CLOSE && depth_ff != '0) begin
                     depth_in = depth_ff - 1'b1;
                  end
                  scan_idx_in  = scan_up;
                  prog_rd_addr = scan_up[PA_W-1:0];
               end
            end else begin
               if (prog_rd_data == tli_pkg::CH_OPEN && depth_ff == PC_W'(1)) begin
                  pc_in    = scan_up;
                  state_in = tli_pkg::S_DONE;
               end else if (scan_idx_ff == '0) begin
                  // stray close bracket
                  pc_in    = pc_next;
                  state_in = tli_pkg::S_DONE;
               end else begin
                  if (prog_rd_data == tli_pkg::CH_CLOSE) begin
                     depth_in = depth_ff + 1'b1;
                  end else if (prog_rd_data == tli_pkg::CH_OPEN) begin
                     depth_in = depth_ff - 1'b1;
                  end
                  scan_idx_in  = scan_down;
                  prog_rd_addr = scan_down[PA_W-1:0];
               end
            end
         end

         tli_pkg::S_CLEAR: begin
            if (!tape_busy) begin
               state_in = tli_pkg::S_DONE;
            end
         end

         tli_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_ovalid_ff;
               rsp_data_in  = {6'd0, res_err_ff, finished, res_byte_ff};
               state_in     = tli_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = tli_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tli_pkg::S_IDLE;
         dp_ff        <= '0;
         pc_ff        <= '0;
         len_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dp_ff        <= dp_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      depth_ff      <= depth_in;
      scan_back_ff  <= scan_back_in;
      cell_ff       <= cell_in;
      ibyte_ff      <= ibyte_in;
      res_ovalid_ff <= res_ovalid_in;
      res_byte_ff   <= res_byte_in;
      res_err_ff    <= res_err_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[dv/tb_tape_language_interpreter_core.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_tape_language_interpreter_core
// Self-checking bench for the stepped tape language machine: directed command,
// bracket, error and reset sequences, then random mostly balanced programs mixed
// with noise, all checked item by item against an in-bench model of the machine.
// -----------------------------------------------------------------------------
module tb_tape_language_interpreter_core;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       fin;
      logic       err;
   } step_result_type;

   localparam logic [7:0] CH_JUNK_LO = 8'h00;
   localparam logic [7:0] CH_JUNK_HI = 8'hFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;
   logic [1:0]  req_tuser = tli_pkg::OP_CLEAR_PROG;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   // machine model state
   logic [7:0]               tape_model [tli_pkg::TAPE_CELLS];
   logic [tli_pkg::DP_W-1:0] ptr;
   logic [7:0]               prog_mem [tli_pkg::PROGRAM_CHARS];
   int                       prog_len;
   int                       pc;
   bit                       halted;

   step_result_type expected_results [$];
   int              mismatch_count = 0;
   int              items_sent = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;

   tape_language_interpreter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   initial begin
      #100_000_000;
      $display("tb_tape_language_interpreter_core: done, errors");
      $finish;
   end

   function automatic void wipe_machine();
      for (int i = 0; i < tli_pkg::TAPE_CELLS; i++) tape_model[i] = 8'h00;
      ptr = '0;
      pc = 0;
      halted = 1'b0;
   endfunction

   function automatic step_result_type model_item(tli_pkg::op_type op, logic [7:0] pchar,
                                                  logic [7:0] ibyte);
      step_result_type r;
      int nxt;
      int m;
      int depth;
      int i;
      bit found;
      r = '0;
      case (op)
         tli_pkg::OP_CLEAR_PROG: begin
            prog_len = 0;
            pc = 0;
            halted = 1'b0;
         end
         tli_pkg::OP_APPEND: begin
            if (prog_len < tli_pkg::PROGRAM_CHARS) begin
               prog_mem[prog_len] = pchar;
               prog_len++;
            end
         end
         tli_pkg::OP_RESET: wipe_machine();
         default: begin
            if (!halted && pc < prog_len) begin
               nxt = pc + 1;
               case (prog_mem[pc])
                  tli_pkg::CH_RIGHT: if (ptr != tli_pkg::DP_MAX) ptr++;
                  tli_pkg::CH_LEFT:  if (ptr != 0) ptr--;
                  tli_pkg::CH_INC:   tape_model[ptr] = tape_model[ptr] + 8'd1;
                  tli_pkg::CH_DEC:   tape_model[ptr] = tape_model[ptr] - 8'd1;
                  tli_pkg::CH_OUT: begin
                     r.out_valid = 1'b1;
                     r.out_byte = tape_model[ptr];
                  end
                  tli_pkg::CH_IN: tape_model[ptr] = ibyte;
                  tli_pkg::CH_OPEN: begin
                     found = 1'b0;
                     depth = 0;
                     m = 0;
                     for (i = pc; i < prog_len && !found; i++) begin
                        if (prog_mem[i] == tli_pkg::CH_OPEN) depth++;
                        else if (prog_mem[i] == tli_pkg::CH_CLOSE) begin
                           if (depth == 1) begin
                              found = 1'b1;
                              m = i;
                           end else if (depth > 0) depth--;
                        end
                     end
                     if (found) begin
                        if (tape_model[ptr] == 8'h00) nxt = m + 1;
                     end else begin
                        wipe_machine();
                        halted = 1'b1;
                        r.err = 1'b1;
                        nxt = 0;
                     end
                  end
                  tli_pkg::CH_CLOSE: begin
                     if (tape_model[ptr] != 8'h00) begin
                        found = 1'b0;
                        depth = 0;
                        for (i = pc; i >= 0 && !found; i--) begin
                           if (prog_mem[i] == tli_pkg::CH_CLOSE) depth++;
                           else if (prog_mem[i] == tli_pkg::CH_OPEN) begin
                              if (depth == 1) begin
                                 found = 1'b1;
                                 nxt = i + 1;
                              end else depth--;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
               pc = nxt;
            end
         end
      endcase
      r.fin = halted || (pc >= prog_len);
      return r;
   endfunction

   task automatic send_item(input tli_pkg::op_type op, input logic [7:0] pchar,
                            input logic [7:0] ibyte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ibyte, pchar};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(model_item(op, pchar, ibyte));
      items_sent++;
   endtask

   task automatic issue_op(input tli_pkg::op_type op);
      send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic append_char(input logic [7:0] c);
      send_item(tli_pkg::OP_APPEND, c, 8'($urandom_range(255)));
   endtask

   task automatic step_once(input logic [7:0] ibyte);
      send_item(tli_pkg::OP_STEP, 8'($urandom_range(255)), ibyte);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // pointer floor, cell wrap both ways, output, input, ignored chars, run past end
   task automatic test_basic_commands();
      issue_op(tli_pkg::OP_CLEAR_PROG);
      step_once(8'h00);
      append_char(tli_pkg::CH_LEFT);
      append_char(tli_pkg::CH_DEC);
      append_char(tli_pkg::CH_OUT);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_OUT);
      append_char(tli_pkg::CH_IN);
      append_char(tli_pkg::CH_OUT);
      append_char(tli_pkg::CH_RIGHT);
      append_char(CH_JUNK_LO);
      append_char(CH_JUNK_HI);
      repeat (5) step_once(8'h00);
      step_once(8'hFF);
      repeat (5) step_once(8'h00);
   endtask

   // loop back, skip on zero cell, stray close
   task automatic test_brackets();
      issue_op(tli_pkg::OP_CLEAR_PROG);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_OPEN);
      append_char(tli_pkg::CH_DEC);
      append_char(tli_pkg::CH_CLOSE);
      append_char(tli_pkg::CH_OPEN);
      append_char(tli_pkg::CH_OUT);
      append_char(tli_pkg::CH_CLOSE);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_CLOSE);
      repeat (11) step_once(8'($urandom_range(255)));
   endtask

   task automatic test_unclosed_bracket();
      issue_op(tli_pkg::OP_CLEAR_PROG);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_OUT);
      append_char(tli_pkg::CH_OPEN);
      repeat (4) step_once(8'($urandom_range(255)));
      issue_op(tli_pkg::OP_CLEAR_PROG);
      step_once(8'($urandom_range(255)));
   endtask

   // program survives a machine reset, tape does not
   task automatic test_machine_reset();
      issue_op(tli_pkg::OP_CLEAR_PROG);
      append_char(tli_pkg::CH_RIGHT);
      append_char(tli_pkg::CH_INC);
      append_char(tli_pkg::CH_OUT);
      repeat (3) step_once(8'($urandom_range(255)));
      issue_op(tli_pkg::OP_RESET);
      repeat (3) step_once(8'($urandom_range(255)));
   endtask

   task automatic run_random_program();
      logic [7:0] body [$];
      int depth;
      int len;
      int steps;
      int pick;
      int reset_at;
      body = {};
      depth = 0;
      len = $urandom_range(24, 3);
      body.push_back($urandom_range(1) ? tli_pkg::CH_IN : tli_pkg::CH_INC);
      for (int i = 1; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 25) body.push_back(tli_pkg::CH_INC);
         else if (pick < 37) body.push_back(tli_pkg::CH_DEC);
         else if (pick < 52) body.push_back(tli_pkg::CH_RIGHT);
         else if (pick < 60) body.push_back(tli_pkg::CH_LEFT);
         else if (pick < 69) body.push_back(tli_pkg::CH_OUT);
         else if (pick < 75) body.push_back(tli_pkg::CH_IN);
         else if (pick < 85) begin
            if (depth < 3) begin
               body.push_back(tli_pkg::CH_OPEN);
               depth++;
            end else body.push_back(tli_pkg::CH_INC);
         end else if (pick < 95) begin
            if (depth > 0) begin
               body.push_back(tli_pkg::CH_CLOSE);
               depth--;
            end else if ($urandom_range(4) == 0) body.push_back(tli_pkg::CH_CLOSE);
            else body.push_back(tli_pkg::CH_DEC);
         end else body.push_back(8'($urandom_range(255)));
      end
      // mostly balanced, now and then left open
      if ($urandom_range(9) != 0) begin
         while (depth > 0) begin
            body.push_back(tli_pkg::CH_CLOSE);
            depth--;
         end
      end
      issue_op(tli_pkg::OP_CLEAR_PROG);
      foreach (body[k]) append_char(body[k]);
      steps = $urandom_range(3 * body.size() + 4, body.size());
      reset_at = ($urandom_range(11) == 0) ? $urandom_range(steps - 1) : -1;
      for (int i = 0; i < steps; i++) begin
         if (i == reset_at) issue_op(tli_pkg::OP_RESET);
         if ($urandom_range(99) < 7) begin
            send_item(tli_pkg::op_type'($urandom_range(2)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         end
         step_once(8'($urandom_range(255)));
      end
   endtask

   task automatic test_random_programs(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) run_random_program();
   endtask

   always @(posedge clock) begin : check_results
      step_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.out_valid ||
                rsp_tdata !== {6'b000000, want.err, want.fin, want.out_byte}) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp valid=%0b byte=%02h fin=%0b err=%0b, %s",
                           want.out_valid, want.out_byte, want.fin, want.err,
                           $sformatf("got valid=%0b byte=%02h fin=%0b err=%0b pad=%b",
                                     rsp_tuser, rsp_tdata[7:0], rsp_tdata[8],
                                     rsp_tdata[9], rsp_tdata[15:10]));
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      wipe_machine();
      prog_len = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_idle(23, 60);
      test_basic_commands();
      test_brackets();
      test_unclosed_bracket();
      test_machine_reset();
      test_random_programs(500);

      set_idle(60, 23);
      test_random_programs(500);

      set_idle(0, 0);
      test_random_programs(500);

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_tape_language_interpreter_core: done, clean");
      end else begin
         $display("tb_tape_language_interpreter_core: done, errors");
      end
      $finish;
   end

endmodule
